@@ sv/ducking_gain_smoother_core_assert.svh @@
// Assertion macros for the ducking gain smoother checker.
// Depends on nothing; included by the checker file.
`ifndef DUCKING_GAIN_SMOOTHER_CORE_ASSERT_SVH
`define DUCKING_GAIN_SMOOTHER_CORE_ASSERT_SVH

// same-cycle implication
`define DGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dgs assertion failed");

// next-cycle implication
`define DGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dgs assertion failed");

`endif

@@ sv/dgs_pkg.sv @@
// Shared types and constants for the ducking gain smoother.
// No dependencies; imported by every module of the block.
package dgs_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_W      = 24;
  localparam int LEN_W       = 13;
  localparam int Q31_W       = 32;
  localparam int LANE_X_W    = SAMPLE_BITS + 1;

  localparam logic [GAIN_W-1:0] UNITY_Q23        = 24'd8388608;
  localparam logic [Q31_W-1:0]  UNITY_Q31        = 32'h8000_0000;
  localparam logic [LEN_W-1:0]  MAX_STAIR_FRAMES = 13'd4096;

  localparam logic FUNC_BLOCK = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_SIDES   = 2'd2;

  typedef struct packed {
    logic mul_en;
    logic rnd_en;
    logic sides;
  } lane_ctrl_t;

endpackage

@@ sv/dgs_divider.sv @@
// Iterative restoring divider for the ramp step, one quotient bit per cycle.
// Depends on dgs_pkg.
module dgs_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dgs_pkg::Q31_W-1:0]  dividend_i,
  input  logic [dgs_pkg::LEN_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [dgs_pkg::Q31_W-1:0]  quotient_o
);
  import dgs_pkg::*;

  localparam int CNT_W = $clog2(Q31_W);

  logic [LEN_W-1:0] rem_q, rem_d, div_q;
  logic [Q31_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [LEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[Q31_W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_d = ge ? LEN_W'(trial - {1'b0, div_q}) : trial[LEN_W-1:0];
    quo_d = {quo_q[Q31_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(Q31_W - 1);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/dgs_lane.sv @@
// One channel lane: gain multiply, sides-mode mid-term merge, round and saturate.
// Depends on dgs_pkg.
module dgs_lane (
  input  logic                                 clk_i,
  input  dgs_pkg::lane_ctrl_t                  ctrl_i,
  input  logic signed [dgs_pkg::LANE_X_W-1:0]  x_i,
  input  logic signed [dgs_pkg::LANE_X_W-1:0]  mid_i,
  input  logic [dgs_pkg::Q31_W-1:0]            gain_i,
  output logic signed [dgs_pkg::SAMPLE_BITS-1:0] res_o
);
  import dgs_pkg::*;

  localparam int PROD_W = LANE_X_W + Q31_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_W  = ACC_W - Q31_W;

  logic signed [PROD_W-1:0]      prod_q;
  logic signed [SAMPLE_BITS-1:0] res_q;
  logic signed [ACC_W-1:0]       base, term, acc, acc_r;
  logic signed [RND_W-1:0]       rnd;
  logic signed [SAMPLE_BITS-1:0] sat;

  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(1 <<< (SAMPLE_BITS - 1));

  always_comb begin
    if (ctrl_i.sides) begin
      base = {{(ACC_W - LANE_X_W - Q31_W + 1){mid_i[LANE_X_W-1]}}, mid_i, {(Q31_W-1){1'b0}}};
      term = {{2{prod_q[PROD_W-1]}}, prod_q};
    end else begin
      base = '0;
      term = {prod_q[PROD_W-1], prod_q, 1'b0};
    end
    acc   = base + term;
    acc_r = acc + (ACC_W'(1) <<< (Q31_W - 1)) - ACC_W'(acc[ACC_W-1]);
    rnd   = acc_r[ACC_W-1:Q31_W];
    if (rnd > SAT_HI) begin
      sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd < SAT_LO) begin
      sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= x_i * $signed({1'b0, gain_i});
    end
    if (ctrl_i.rnd_en) begin
      res_q <= sat;
    end
  end

  assign res_o = res_q;

endmodule

@@ sv/ducking_gain_smoother_core.sv @@
// Top level of the ducking gain smoother: sequencer, ramp and smoother state,
// APB registers, two channel lanes and the output register. Uses dgs_pkg,
// dgs_divider and dgs_lane.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o| func, gain_target, block_length, left, right
//  out     | out_valid_o/out_stall_i| left_out, right_out, applied_gain
//  cfg     | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// Frame item: one at a time through the ramp, smoother, lane and output states;
// stalls only at the output register. Block-start item with a new target: waits
// on the one-bit-per-cycle divider. Unchanged target or zero length: no wait.
// Reset loads unity gain and unity coefficients; no clearing pass.
module ducking_gain_smoother_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   func_i,
  input  logic [dgs_pkg::GAIN_W-1:0]             gain_target_i,
  input  logic [dgs_pkg::LEN_W-1:0]              block_length_i,
  input  logic signed [dgs_pkg::SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [dgs_pkg::SAMPLE_BITS-1:0] right_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [dgs_pkg::SAMPLE_BITS-1:0] left_out_o,
  output logic signed [dgs_pkg::SAMPLE_BITS-1:0] right_out_o,
  output logic [dgs_pkg::GAIN_W-1:0]             applied_gain_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);
  import dgs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_RAMP, ST_SMUL, ST_SUPD, ST_LMUL, ST_LRND, ST_OUT
  } state_e;

  localparam int STEP_W = Q31_W + 1;
  localparam int SPROD_W = GAIN_W + 1 + STEP_W;
  localparam int SUM_W = Q31_W + 3;

  state_e state_q;

  logic [GAIN_W-1:0]  attack_q, release_q;
  logic               sides_q;
  logic [Q31_W-1:0]   sg_q, rv_q;
  logic [GAIN_W-1:0]  last_q;
  logic signed [STEP_W-1:0] step_q;
  logic [LEN_W-1:0]   rfl_q, fsc_q;
  logic               neg_q;
  logic signed [SAMPLE_BITS-1:0] l_q, r_q;
  logic signed [SPROD_W-1:0] sprod_q;
  logic               out_valid_q;
  logic signed [SAMPLE_BITS-1:0] left_out_q, right_out_q;
  logic [GAIN_W-1:0]  gain_out_q;

  // block-start path
  logic                 accept, cfg_wr;
  logic [GAIN_W-1:0]    tgt, wr_val;
  logic [Q31_W-1:0]     tq, mag;
  logic signed [STEP_W-1:0] diff;
  logic                 up, changed;
  logic [LEN_W-1:0]     width, fsc_base, fsc_d;
  logic [LEN_W:0]       fsc_sum;

  // frame path
  logic signed [SUM_W-1:0]   ramp_sum, sm_sum;
  logic [Q31_W-1:0]          rv_d, sg_d;
  logic [GAIN_W-1:0]         coeff;
  logic signed [STEP_W-1:0]  gdiff;
  logic signed [SPROD_W-1:0] sm_acc;
  logic signed [SUM_W-1:0]   sm_r;
  logic [Q31_W-1:0]          ag_sum;
  logic                      out_load;

  logic                      div_done;
  logic [Q31_W-1:0]          div_quo;
  logic [STEP_W-1:0]         quo_ext;

  lane_ctrl_t                lane_ctrl;
  logic signed [LANE_X_W-1:0] mid, x_l, x_r;
  logic signed [SAMPLE_BITS-1:0] res_l, res_r;

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_val = (pwdata[GAIN_W-1:0] > UNITY_Q23) ? UNITY_Q23 : pwdata[GAIN_W-1:0];

  always_comb begin
    tgt      = (gain_target_i > UNITY_Q23) ? UNITY_Q23 : gain_target_i;
    tq       = {tgt, 8'b0};
    up       = tq >= rv_q;
    changed  = tgt != last_q;
    width    = (up && (fsc_q > block_length_i)) ? fsc_q : block_length_i;
    diff     = $signed({1'b0, tq}) - $signed({1'b0, rv_q});
    mag      = diff[STEP_W-1] ? Q31_W'(-diff) : diff[Q31_W-1:0];
    fsc_base = changed ? '0 : fsc_q;
    fsc_sum  = {1'b0, fsc_base} + {1'b0, block_length_i};
    fsc_d    = (fsc_sum > {1'b0, MAX_STAIR_FRAMES}) ? MAX_STAIR_FRAMES : fsc_sum[LEN_W-1:0];
  end

  always_comb begin
    ramp_sum = $signed({3'b0, rv_q}) + SUM_W'(step_q);
    if (rfl_q == LEN_W'(1)) begin
      rv_d = {last_q, 8'b0};
    end else if (ramp_sum < 0) begin
      rv_d = '0;
    end else if (ramp_sum > $signed({3'b0, UNITY_Q31})) begin
      rv_d = UNITY_Q31;
    end else begin
      rv_d = ramp_sum[Q31_W-1:0];
    end
    coeff  = (rv_q < sg_q) ? attack_q : release_q;
    gdiff  = $signed({1'b0, rv_q}) - $signed({1'b0, sg_q});
    sm_acc = sprod_q + (SPROD_W'(1) <<< 22) - SPROD_W'(sprod_q[SPROD_W-1]);
    sm_r   = sm_acc[SPROD_W-1:23];
    sm_sum = $signed({3'b0, sg_q}) + sm_r;
    if (sm_sum < 0) begin
      sg_d = '0;
    end else if (sm_sum > $signed({3'b0, UNITY_Q31})) begin
      sg_d = UNITY_Q31;
    end else begin
      sg_d = sm_sum[Q31_W-1:0];
    end
    ag_sum  = sg_q + Q31_W'(128);
    quo_ext = {1'b0, div_quo};
  end

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      attack_q    <= UNITY_Q23;
      release_q   <= UNITY_Q23;
      sides_q     <= 1'b0;
      sg_q        <= UNITY_Q31;
      rv_q        <= UNITY_Q31;
      last_q      <= UNITY_Q23;
      step_q      <= '0;
      rfl_q       <= '0;
      fsc_q       <= '0;
      neg_q       <= 1'b0;
      l_q         <= '0;
      r_q         <= '0;
      sprod_q     <= '0;
      out_valid_q <= 1'b0;
      left_out_q  <= '0;
      right_out_q <= '0;
      gain_out_q  <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ATTACK:  attack_q  <= wr_val;
          REG_RELEASE: release_q <= wr_val;
          REG_SIDES:   sides_q   <= pwdata[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (func_i == FUNC_FRAME) begin
              l_q     <= left_in_i;
              r_q     <= right_in_i;
              state_q <= ST_RAMP;
            end else if (block_length_i != '0) begin
              fsc_q <= fsc_d;
              if (changed) begin
                neg_q   <= diff[STEP_W-1];
                rfl_q   <= width;
                last_q  <= tgt;
                state_q <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_q  <= neg_q ? -$signed(quo_ext) : $signed(quo_ext);
            state_q <= ST_IDLE;
          end
        end
        ST_RAMP: begin
          if (rfl_q != '0) begin
            rv_q  <= rv_d;
            rfl_q <= rfl_q - 1'b1;
          end
          state_q <= ST_SMUL;
        end
        ST_SMUL: begin
          sprod_q <= $signed({1'b0, coeff}) * gdiff;
          state_q <= ST_SUPD;
        end
        ST_SUPD: begin
          sg_q    <= sg_d;
          state_q <= ST_LMUL;
        end
        ST_LMUL: state_q <= ST_LRND;
        ST_LRND: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            left_out_q  <= res_l;
            right_out_q <= res_r;
            gain_out_q  <= ag_sum[Q31_W-1:8];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  dgs_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && (func_i == FUNC_BLOCK) && (block_length_i != '0) && changed),
    .dividend_i (mag),
    .divisor_i  (width),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    lane_ctrl.mul_en = state_q == ST_LMUL;
    lane_ctrl.rnd_en = state_q == ST_LRND;
    lane_ctrl.sides  = sides_q;
    mid = LANE_X_W'(l_q) + LANE_X_W'(r_q);
    x_l = sides_q ? LANE_X_W'(l_q) - LANE_X_W'(r_q) : LANE_X_W'(l_q);
    x_r = sides_q ? LANE_X_W'(r_q) - LANE_X_W'(l_q) : LANE_X_W'(r_q);
  end

  dgs_lane u_lane_left (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .x_i    (x_l),
    .mid_i  (mid),
    .gain_i (sg_q),
    .res_o  (res_l)
  );

  dgs_lane u_lane_right (
    .clk_i  (clk_i),
    .ctrl_i (lane_ctrl),
    .x_i    (x_r),
    .mid_i  (mid),
    .gain_i (sg_q),
    .res_o  (res_r)
  );

  always_comb begin
    case (paddr[3:2])
      REG_ATTACK:  prdata = {8'b0, attack_q};
      REG_RELEASE: prdata = {8'b0, release_q};
      REG_SIDES:   prdata = {31'b0, sides_q};
      default:     prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign in_stall_o     = state_q != ST_IDLE;
  assign out_valid_o    = out_valid_q;
  assign left_out_o     = left_out_q;
  assign right_out_o    = right_out_q;
  assign applied_gain_o = gain_out_q;

endmodule

@@ sv/dgs_checker.sv @@
// Port-level checker for the ducking gain smoother, bound to the top level.
// Depends on dgs_pkg and ducking_gain_smoother_core_assert.svh.
`include "ducking_gain_smoother_core_assert.svh"

module dgs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             func_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [dgs_pkg::GAIN_W-1:0]       applied_gain_o
);
  import dgs_pkg::*;

  `DGS_ASSERT_NOW(a_gain_max, clk_i, rst_ni, out_valid_o, applied_gain_o <= UNITY_Q23)

  `DGS_ASSERT_NEXT(a_frame_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (func_i == FUNC_FRAME), in_stall_o)

  `DGS_ASSERT_NOW(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  `DGS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind ducking_gain_smoother_core dgs_checker u_checker (.*);

@@ bench/tb_top.sv @@
// Testbench for ducking_gain_smoother_core: directed and random block-start and frame
// items, with an item-level predictor of the ramp, smoother and channel scaling.
// Depends on dgs_pkg and ducking_gain_smoother_core.
module tb_top;
  import dgs_pkg::*;

  localparam longint GAIN_ONE     = longint'(UNITY_Q31);
  localparam longint STAIR_CAP    = longint'(MAX_STAIR_FRAMES);
  localparam int     SETTLE_CYCLES = 48;
  localparam int     QUIET_LIMIT  = 4000;
  localparam int     PHASE_ITEMS  = 245;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [GAIN_W-1:0]             gain;
  } frame_out_t;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          func_i         = FUNC_BLOCK;
  logic [GAIN_W-1:0]             gain_target_i  = '0;
  logic [LEN_W-1:0]              block_length_i = '0;
  logic signed [SAMPLE_BITS-1:0] left_in_i      = '0;
  logic signed [SAMPLE_BITS-1:0] right_in_i     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic signed [SAMPLE_BITS-1:0] left_out_o;
  logic signed [SAMPLE_BITS-1:0] right_out_o;
  logic [GAIN_W-1:0]             applied_gain_o;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [3:0]                    paddr          = '0;
  logic [31:0]                   pwdata         = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // predicted block state, gains in Q1.31
  longint            gain_q31     = GAIN_ONE;
  longint            ramp_q31     = GAIN_ONE;
  longint            ramp_inc_q31 = 0;
  longint            ramp_frames  = 0;
  longint            stair_frames = 0;
  logic [GAIN_W-1:0] target_q23   = UNITY_Q23;
  logic [GAIN_W-1:0] coef_fall    = UNITY_Q23;
  logic [GAIN_W-1:0] coef_rise    = UNITY_Q23;
  logic              side_only    = 1'b0;

  frame_out_t scaled_frames_q[$];
  frame_out_t exp_frame;
  int         mismatches  = 0;
  int         items_sent  = 0;
  int         quiet_count = 0;
  bit         steady_run  = 1'b0;

  ducking_gain_smoother_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .gain_target_i  (gain_target_i),
    .block_length_i (block_length_i),
    .left_in_i      (left_in_i),
    .right_in_i     (right_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .applied_gain_o (applied_gain_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] v);
    return (v > UNITY_Q23) ? UNITY_Q23 : v;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic void predict_block_start(input logic [GAIN_W-1:0] tgt_in,
                                              input logic [LEN_W-1:0] len);
    logic [GAIN_W-1:0] tgt;
    longint tq, width, stair;
    tgt = clamp_gain(tgt_in);
    if (len == 0) return;
    if (tgt != target_q23) begin
      tq = longint'(tgt) <<< 8;
      width = longint'(len);
      if (tq >= ramp_q31) begin
        stair = (stair_frames > STAIR_CAP) ? STAIR_CAP : stair_frames;
        if (stair > width) width = stair;
      end
      ramp_inc_q31 = (tq - ramp_q31) / width;
      ramp_frames = width;
      stair_frames = 0;
      target_q23 = tgt;
    end
    stair_frames = stair_frames + longint'(len);
    if (stair_frames > STAIR_CAP) stair_frames = STAIR_CAP;
  endfunction

  function automatic void predict_frame(input logic signed [SAMPLE_BITS-1:0] l_in,
                                        input logic signed [SAMPLE_BITS-1:0] r_in);
    longint coef, lx, rx, lo, ro, mid, side, ag;
    frame_out_t res;
    if (ramp_frames > 0) begin
      ramp_q31 = ramp_q31 + ramp_inc_q31;
      ramp_frames = ramp_frames - 1;
      if (ramp_frames == 0) ramp_q31 = longint'(target_q23) <<< 8;
      if (ramp_q31 < 0) ramp_q31 = 0;
      if (ramp_q31 > GAIN_ONE) ramp_q31 = GAIN_ONE;
    end
    coef = (ramp_q31 < gain_q31) ? longint'(coef_fall) : longint'(coef_rise);
    gain_q31 = gain_q31 + round_shift(coef * (ramp_q31 - gain_q31), 23);
    if (gain_q31 < 0) gain_q31 = 0;
    if (gain_q31 > GAIN_ONE) gain_q31 = GAIN_ONE;
    lx = l_in;
    rx = r_in;
    if (side_only) begin
      mid  = (lx + rx) * GAIN_ONE;
      side = (lx - rx) * gain_q31;
      lo = round_shift(mid + side, 32);
      ro = round_shift(mid - side, 32);
    end else begin
      lo = round_shift(lx * gain_q31, 31);
      ro = round_shift(rx * gain_q31, 31);
    end
    ag = (gain_q31 + 128) >>> 8;
    if (ag > longint'(UNITY_Q23)) ag = longint'(UNITY_Q23);
    res.left  = sat_sample(lo);
    res.right = sat_sample(ro);
    res.gain  = ag[GAIN_W-1:0];
    scaled_frames_q.push_back(res);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_target();
    case ($urandom_range(5))
      0: return '0;
      1: return UNITY_Q23;
      2: return target_q23;
      3: return UNITY_Q23 + $urandom_range(1, 8388607);
      default: return $urandom_range(0, 8388608);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(19))
      0: return '0;
      1: return MAX_STAIR_FRAMES;
      2: return $urandom_range(4097, 8191);
      3, 4: return $urandom_range(33, 4095);
      default: return $urandom_range(1, 32);
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'(UNITY_Q23);
      2: return $urandom;
      3: return $urandom_range(0, 65535);
      default: return $urandom_range(0, 8388608);
    endcase
  endfunction

  // Called at a rising edge. Leaves valid high on return so that a following item
  // can go back to back; wait_idle lowers it in the same step otherwise.
  task automatic send_item(input logic f, input logic [GAIN_W-1:0] tgt,
                           input logic [LEN_W-1:0] len,
                           input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r);
    bit lowered;
    lowered = 1'b0;
    while (!steady_run && $urandom_range(99) < 28) begin
      if (!lowered) in_valid_i <= 1'b0;
      lowered = 1'b1;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= f;
    gain_target_i  <= tgt;
    block_length_i <= len;
    left_in_i      <= l;
    right_in_i     <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (f == FUNC_FRAME) predict_frame(l, r);
    else predict_block_start(tgt, len);
    items_sent++;
  endtask

  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r);
    send_item(FUNC_FRAME, $urandom, $urandom, l, r);
  endtask

  task automatic send_block(input logic [GAIN_W-1:0] tgt, input logic [LEN_W-1:0] len);
    send_item(FUNC_BLOCK, tgt, len, $urandom, $urandom);
  endtask

  // lowers valid and lets the block finish any ramp setup before returning
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scaled_frames_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ATTACK:  coef_fall = clamp_gain(value[GAIN_W-1:0]);
      REG_RELEASE: coef_rise = clamp_gain(value[GAIN_W-1:0]);
      REG_SIDES:   side_only = value[0];
      default: ;
    endcase
  endtask

  task automatic test_unity_frames();
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    send_frame('0, '1);
    send_frame(rand_sample(), rand_sample());
    wait_idle();
  endtask

  task automatic test_ramp_cases();
    send_block('0, 13'd3);
    repeat (4) send_frame(rand_sample(), rand_sample());
    send_block('0, 13'd5);
    send_block(24'hFFFFFF, '0);
    send_block(24'hFFFFFF, 13'd1);
    repeat (3) send_frame(24'sh7FFFFF, 24'sh7FFFFF);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_ATTACK, '0);
    write_reg(REG_RELEASE, '0);
    send_block(24'h200000, 13'd2);
    repeat (2) send_frame(rand_sample(), rand_sample());
    wait_idle();
    write_reg(REG_ATTACK, 32'hFFFF_FFFF);
    write_reg(REG_SIDES, 32'd1);
    send_block(24'h400000, 13'h1FFF);
    send_frame(24'sh7FFFFF, 24'sh800000);
    send_frame(24'sh800000, 24'sh7FFFFF);
    send_frame(24'sh7FFFFF, 24'sh7FFFFF);
    wait_idle();
    write_reg(REG_RELEASE, 32'(UNITY_Q23));
    write_reg(REG_SIDES, '0);
  endtask

  // block starts, each followed by up to 24 frames, with zero-length
  // blocks, repeated targets and frames past the block end mixed in
  task automatic test_random_traffic();
    int phase, first, n;
    logic [LEN_W-1:0] len;
    for (phase = 0; phase < 5; phase++) begin
      steady_run = (phase == 2);
      write_reg(REG_ATTACK, pick_coeff());
      write_reg(REG_RELEASE, pick_coeff());
      write_reg(REG_SIDES, $urandom);
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
        len = pick_length();
        send_block(pick_target(), len);
        n = $urandom_range(0, (len < 22) ? int'(len) + 2 : 24);
        repeat (n) send_frame(rand_sample(), rand_sample());
      end
      wait_idle();
    end
    steady_run = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (scaled_frames_q.size() == 0) begin
        $error("frame result with none expected");
        mismatches++;
      end else begin
        exp_frame = scaled_frames_q.pop_front();
        if (left_out_o !== exp_frame.left) begin
          $error("left_out: expected %0d, got %0d", exp_frame.left, left_out_o);
          mismatches++;
        end
        if (right_out_o !== exp_frame.right) begin
          $error("right_out: expected %0d, got %0d", exp_frame.right, right_out_o);
          mismatches++;
        end
        if (applied_gain_o !== exp_frame.gain) begin
          $error("applied_gain: expected %0d, got %0d", exp_frame.gain, applied_gain_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= rst_ni && !steady_run && ($urandom_range(99) < 28);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= QUIET_LIMIT) begin
      $display("ducking_gain_smoother_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unity_frames();
    test_ramp_cases();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && scaled_frames_q.size() == 0)
      $display("ducking_gain_smoother_core test passed");
    else
      $display("ducking_gain_smoother_core test failed");
    $finish;
  end

endmodule
